/* rtl/line_substring_matcher_unit_macros.svh */
// Assertion macros used by the checker file lsm_checker.sv.
`ifndef LINE_SUBSTRING_MATCHER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lsm_pkg.sv */
package lsm_pkg;

    localparam int PATTERN_MAX    = 32;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 6;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int BYTES_PER_WORD = CFG_W / BYTE_W;
    localparam int PAT_WORDS      = 4;
    localparam int WORD_SEL_W     = 2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE = 3'd5;

    localparam t_byte ASCII_UPPER_A = 8'h41;
    localparam t_byte ASCII_UPPER_Z = 8'h5A;
    localparam t_byte CASE_OFFSET   = 8'h20;

    // Control handed to every cell of the chain
    typedef struct packed {
        logic  step;   // a present byte is consumed this cycle
        logic  clear;  // line finished, drop partial matches
        logic  fold;   // ASCII case folding on
        t_byte char;   // folded text byte
    } t_cell_ctrl;

    function automatic t_byte fold_byte(input logic fold, input t_byte b);
        if (fold && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

    function automatic t_len clamp_len(input t_len len);
        if (len > t_len'(PATTERN_MAX)) begin
            return t_len'(PATTERN_MAX);
        end
        return len;
    endfunction

endpackage

/* rtl/lsm_if.sv */
interface lsm_in_if import lsm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  byte_present;
    logic  line_end;

    modport source (output valid, text_byte, byte_present, line_end, input ready);
    modport sink   (input valid, text_byte, byte_present, line_end, output ready);
endinterface

interface lsm_out_if ();
    logic valid;
    logic ready;
    logic line_matches;

    modport source (output valid, line_matches, input ready);
    modport sink   (input valid, line_matches, output ready);
endinterface

/* rtl/lsm_cell.sv */
module lsm_cell import lsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_byte      i_pat_byte,
    input  logic       i_en,       // position lies inside the pattern length
    input  logic       i_is_last,  // position is the final pattern byte
    input  logic       i_prev,     // partial match of the left neighbour
    output logic       o_pm,
    output logic       o_full      // full match completes on this byte
);

    logic r_pm;
    logic n_pm;

    assign n_pm   = i_prev & i_en & (fold_byte(i_ctrl.fold, i_pat_byte) == i_ctrl.char);
    assign o_full = i_ctrl.step & n_pm & i_is_last;
    assign o_pm   = r_pm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_pm <= 1'b0;
        end else if (i_ctrl.step) begin
            r_pm <= n_pm;
        end
    end

endmodule

/* rtl/lsm_out_buf.sv */
module lsm_out_buf (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic         i_data,
    output logic         o_full,
    lsm_out_if.source    o_out
);

    logic r_out_valid;
    logic r_out_data;
    logic r_skid_valid;
    logic r_skid_data;
    logic take;

    assign take               = r_out_valid & o_out.ready;
    assign o_full             = r_skid_valid;
    assign o_out.valid        = r_out_valid;
    assign o_out.line_matches = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= i_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= i_data;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* rtl/line_substring_matcher_unit.sv */
// A line-end transaction's result is registered into the output register, or into the skid stage.
// Throughput: one byte per cycle while ready is high; all match cells of the chain update together.
// Input stalls only once both output register and skid stage hold unread results.
// Reset (synchronous, active low): partial matches, found flag, output stages cleared;
// pattern words, length and case-fold mode return to zero.
module line_substring_matcher_unit import lsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lsm_in_if.sink               i_in,
    lsm_out_if.source            o_out
);

    // Configuration registers
    logic [CFG_W-1:0] r_pat_words [PAT_WORDS];
    t_len             r_pat_len;
    logic             r_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat_words[w] <= '0;
            end
            r_pat_len <= '0;
            r_fold    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31: begin
                    r_pat_words[i_cfg_idx[WORD_SEL_W-1:0]] <= i_cfg_data;
                end
                CFG_PAT_LEN: begin
                    r_pat_len <= i_cfg_data[LEN_W-1:0];
                end
                CFG_IGNORE_CASE: begin
                    r_fold <= i_cfg_data[0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // Transaction control
    logic       buf_full;
    logic       accept;
    t_len       used_len;
    logic       len_zero;
    t_cell_ctrl ctrl;

    assign i_in.ready = !buf_full;
    assign accept     = i_in.valid & i_in.ready;
    assign used_len   = clamp_len(r_pat_len);
    assign len_zero   = (used_len == '0);

    assign ctrl.step  = accept & i_in.byte_present & !len_zero;
    assign ctrl.clear = accept & i_in.line_end;
    assign ctrl.fold  = r_fold;
    assign ctrl.char  = fold_byte(r_fold, i_in.text_byte);

    // Shift-and chain: cell j holds "pattern bytes 0..j end at the latest byte"
    // and passes that bit to cell j+1 on every consumed byte. Cell 0 always sees a match to its left.
    logic [PATTERN_MAX-1:0] pm;
    logic [PATTERN_MAX-1:0] full;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic prev;

        if (j == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_body
            assign prev = pm[j-1];
        end

        lsm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_pat_byte (r_pat_words[j / BYTES_PER_WORD]
                                    [(j % BYTES_PER_WORD) * BYTE_W +: BYTE_W]),
            .i_en       (t_len'(j) < used_len),
            .i_is_last  (used_len == t_len'(j + 1)),
            .i_prev     (prev),
            .o_pm       (pm[j]),
            .o_full     (full[j])
        );
    end

    // Sticky found flag for the current line
    logic r_found;
    logic hit_now;

    assign hit_now = |full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (ctrl.clear) begin
            r_found <= 1'b0;
        end else if (hit_now) begin
            r_found <= 1'b1;
        end
    end

    // Result of a finished line: includes a match completed by its final byte;
    // an empty pattern matches any line.
    lsm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ctrl.clear),
        .i_data  (r_found | hit_now | len_zero),
        .o_full  (buf_full),
        .o_out   (o_out)
    );

endmodule

/* rtl/lsm_checker.sv */
`include "line_substring_matcher_unit_macros.svh"

module lsm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_line_end,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_matches
);

    `LSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_matches), "result dropped or changed while stalled")

    `LSM_ASSERT_SAME(a_stall_needs_result, i_clk, i_rst_n, !i_in_ready, i_out_valid, "input stalled with no result pending")

    `LSM_ASSERT_NEXT(a_result_from_line_end, i_clk, i_rst_n, !i_out_valid && !(i_in_valid && i_in_ready && i_in_line_end), !i_out_valid, "result without a line-end transaction")

    `LSM_ASSERT_NEXT(a_line_end_gives_result, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_line_end, i_out_valid, "line-end transaction gave no result")

endmodule

bind line_substring_matcher_unit lsm_checker u_lsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_line_end (i_in.line_end),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_matches (o_out.line_matches)
);

/* dv/line_match_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own shift-and
// state, and checks every line verdict against the oldest one expected.
module line_match_checker import lsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lsm_in_if                    i_text_mon,
    lsm_out_if                   i_verdict_mon,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [CFG_W-1:0]       pat_word [PAT_WORDS];
    t_len                   pat_len_reg;
    logic                   fold_on;
    logic [PATTERN_MAX-1:0] prefix_hits;
    logic                   seen_full;
    logic                   verdict_q [$];
    int                     fail_count;
    int                     pending_lines;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_lines;

    function automatic t_byte case_folded(input t_byte c);
        if (fold_on && c >= "A" && c <= "Z") begin
            return c | 8'h20;
        end
        return c;
    endfunction

    // one bit per pattern position holding the same byte as c
    function automatic logic [PATTERN_MAX-1:0] position_hits(input t_byte c, input int n);
        logic [PATTERN_MAX-1:0] mask;
        t_byte                  pb;
        mask = '0;
        for (int j = 0; j < n; j++) begin
            pb = pat_word[j >> 3][(j & 7) * BYTE_W +: BYTE_W];
            if (case_folded(pb) == case_folded(c)) begin
                mask[j] = 1'b1;
            end
        end
        return mask;
    endfunction

    always @(posedge i_clk) begin
        int   n;
        logic want;
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                pat_word[w] = '0;
            end
            pat_len_reg   = '0;
            fold_on       = 1'b0;
            prefix_hits   = '0;
            seen_full     = 1'b0;
            verdict_q.delete();
            pending_lines = 0;
            fail_count    = 0;
        end else begin
            if (i_verdict_mon.valid && i_verdict_mon.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("line_matches: no line pending, actual %0b",
                           i_verdict_mon.line_matches);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    pending_lines--;
                    if (i_verdict_mon.line_matches !== want) begin
                        $error("line_matches: expected %0b, actual %0b",
                               want, i_verdict_mon.line_matches);
                        fail_count++;
                    end
                end
            end

            // a byte taken on the same edge as a register write still sees
            // the old settings
            if (i_text_mon.valid && i_text_mon.ready) begin
                n = (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
                if (i_text_mon.byte_present && n > 0) begin
                    prefix_hits = ((prefix_hits << 1) | 1)
                                  & position_hits(i_text_mon.text_byte, n);
                    if (prefix_hits[n-1]) begin
                        seen_full = 1'b1;
                    end
                end
                if (i_text_mon.line_end) begin
                    verdict_q.push_back(seen_full || n == 0);
                    pending_lines++;
                    prefix_hits = '0;
                    seen_full   = 1'b0;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31: begin
                        pat_word[i_cfg_idx[WORD_SEL_W-1:0]] = i_cfg_data;
                    end
                    CFG_PAT_LEN: begin
                        pat_len_reg = i_cfg_data[LEN_W-1:0];
                    end
                    CFG_IGNORE_CASE: begin
                        fold_on = i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

/* dv/tb_line_substring_matcher_unit.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the line substring matcher. Lines of text go in
// one byte per transaction, one verdict per line comes out; the checker
// beside the block predicts and compares.
module tb_line_substring_matcher_unit;
    import lsm_pkg::*;

    localparam int ITEM_TARGET  = 2000;
    localparam int MAX_GAP      = 10;
    localparam int LONG_HOLD    = 60;    // receiver hold-off, long enough to back up the input
    localparam int SETTLE       = 3;     // settling margin before a register write
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int LEN_REG_MAX  = (1 << LEN_W) - 1;

    localparam logic [CFG_IDX_W-1:0] PAT_REG [PAT_WORDS] =
        '{CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    lsm_in_if  text_ch ();
    lsm_out_if verdict_ch ();

    int fail_count;
    int pending;

    // testbench's own view of the programmed pattern, used to build lines
    t_byte pat_bytes [PATTERN_MAX];
    int    eff_len;
    logic  fold_mode;

    int   items_sent;
    logic src_no_idle;
    logic sink_no_idle;
    logic sink_hold_req;
    logic result_taken;

    line_substring_matcher_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (text_ch),
        .o_out      (verdict_ch)
    );

    line_match_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_text_mon    (text_ch),
        .i_verdict_mon (verdict_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: draws a stall after every verdict transaction; a hold
    // request from the stimulus side forces a long stretch with ready low.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        result_taken <= verdict_ch.valid && verdict_ch.ready;
    end

    initial begin
        int stall_left;
        int hold_left;
        stall_left       = 0;
        hold_left        = 0;
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_taken) begin
                stall_left = sink_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (sink_hold_req) begin
                hold_left     = LONG_HOLD;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                verdict_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                verdict_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                verdict_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register port and text channel drivers; everything changes on the
    // falling edge so the block samples settled values.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // all six registers, from pat_bytes
    task automatic configure(input t_len len_reg, input logic fold);
        logic [CFG_W-1:0] word;
        for (int w = 0; w < PAT_WORDS; w++) begin
            for (int k = 0; k < BYTES_PER_WORD; k++) begin
                word[k*BYTE_W +: BYTE_W] = pat_bytes[w*BYTES_PER_WORD + k];
            end
            write_reg(PAT_REG[w], word);
        end
        write_reg(CFG_PAT_LEN, CFG_W'(len_reg));
        write_reg(CFG_IGNORE_CASE, CFG_W'(fold));
        eff_len   = (len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
        fold_mode = fold;
    endtask

    // letters of both cases, zero and all-ones bytes, and arbitrary bytes
    task automatic load_random_pattern(input t_len len_reg, input logic fold);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            case ($urandom_range(0, 5))
                0: pat_bytes[k] = t_byte'("a" + $urandom_range(0, 25));
                1: pat_bytes[k] = t_byte'("A" + $urandom_range(0, 25));
                2: pat_bytes[k] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
                default: pat_bytes[k] = t_byte'($urandom_range(0, 255));
            endcase
        end
        configure(len_reg, fold);
    endtask

    task automatic send_item(input t_byte b, input logic present, input logic last);
        int gap;
        gap = src_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= b;
        text_ch.byte_present <= present;
        text_ch.line_end     <= last;
        do @(posedge i_clk); while (!text_ch.ready);
        if (present || last) begin
            items_sent++;
        end
    endtask

    // Stop offering, then hold until every verdict is back and the block
    // has had time to finish any byte still in flight.
    task automatic wait_drained();
        @(negedge i_clk);
        text_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // half the text is drawn from the pattern so partial matches build up
    function automatic t_byte any_text_byte();
        if (eff_len > 0 && $urandom_range(0, 1) == 1) begin
            return pat_bytes[$urandom_range(0, eff_len - 1)];
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    // A line of n_bytes, optionally with the pattern planted in it (case
    // flipped at random when folding, now and then with one byte spoilt).
    // Some lines close with a byte-less end marker; noise transactions with
    // neither a byte nor an end are sprinkled in.
    task automatic send_line(input int n_bytes, input bit plant);
        t_byte txt [$];
        t_byte c;
        int    at;
        bit    end_marker;
        for (int k = 0; k < n_bytes; k++) begin
            txt.push_back(any_text_byte());
        end
        if (plant && eff_len > 0) begin
            while (txt.size() < eff_len) begin
                txt.push_back(any_text_byte());
            end
            at = $urandom_range(0, txt.size() - eff_len);
            for (int k = 0; k < eff_len; k++) begin
                c = pat_bytes[k];
                if (fold_mode && (c | 8'h20) >= "a" && (c | 8'h20) <= "z"
                    && $urandom_range(0, 1) == 1) begin
                    c = c ^ CASE_OFFSET;
                end
                txt[at + k] = c;
            end
            if ($urandom_range(0, 4) == 0) begin
                txt[at + $urandom_range(0, eff_len - 1)] = t_byte'($urandom_range(0, 255));
            end
        end
        end_marker = (txt.size() == 0) || ($urandom_range(0, 7) == 0);
        foreach (txt[k]) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(t_byte'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(txt[k], 1'b1, !end_marker && k == txt.size() - 1);
        end
        if (end_marker) begin
            send_item(t_byte'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_len len_pick;
        bit   hold_phase;
        int   n;
        int   phase;

        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_PAT_0_7;
        cfg_data             = '0;
        text_ch.valid        = 1'b0;
        text_ch.text_byte    = '0;
        text_ch.byte_present = 1'b0;
        text_ch.line_end     = 1'b0;
        src_no_idle          = 1'b0;
        sink_no_idle         = 1'b0;
        sink_hold_req        = 1'b0;
        result_taken         = 1'b0;
        items_sent           = 0;
        eff_len              = 0;
        fold_mode            = 1'b0;
        foreach (pat_bytes[k]) begin
            pat_bytes[k] = '0;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset values give an empty pattern, which matches
        // every line, the empty one too
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);

        // zero byte and all-ones byte are ordinary pattern bytes
        wait_drained();
        pat_bytes[0] = 8'h00;
        pat_bytes[1] = 8'hFF;
        configure(t_len'(2), 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);              // empty line, non-empty pattern
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);              // no byte, no end: ignored
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);              // end marker after the last byte

        // case folding applies to text and pattern alike
        wait_drained();
        pat_bytes[0] = "a";
        pat_bytes[1] = "B";
        configure(t_len'(2), 1'b1);
        send_item("A", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b1);

        // folding switched on mid-line: the prefix held so far survives
        wait_drained();
        pat_bytes[1] = "b";
        configure(t_len'(2), 1'b0);
        send_item("a", 1'b1, 1'b0);
        wait_drained();
        write_reg(CFG_IGNORE_CASE, CFG_W'(1'b1));
        fold_mode = 1'b1;
        send_item("B", 1'b1, 1'b1);

        // length above the maximum is clamped
        wait_drained();
        load_random_pattern(t_len'(LEN_REG_MAX), 1'b0);
        send_item(pat_bytes[0], 1'b1, 1'b0);
        send_item(pat_bytes[1], 1'b1, 1'b0);
        send_item(pat_bytes[2], 1'b1, 1'b1);

        // single-byte pattern, folded
        wait_drained();
        pat_bytes[0] = "Z";
        configure(t_len'(1), 1'b1);
        send_item("z", 1'b1, 1'b1);

        // --- random phases: fresh pattern and idling mode each time. The
        // first phase, and the odd one later, holds the receiver off while
        // the sender streams short lines, so verdicts back up into the input.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_drained();
            case ($urandom_range(0, 7))
                0: len_pick = '0;
                1: len_pick = t_len'(1);
                2: len_pick = t_len'(PATTERN_MAX);
                3: len_pick = t_len'($urandom_range(PATTERN_MAX + 1, LEN_REG_MAX));
                default: len_pick = t_len'($urandom_range(2, 8));
            endcase
            load_random_pattern(len_pick, $urandom_range(0, 1) == 1);
            hold_phase   = (phase == 0) || ($urandom_range(0, 9) == 0);
            src_no_idle  = hold_phase || ($urandom_range(0, 3) == 0);
            sink_no_idle = !hold_phase && ($urandom_range(0, 3) == 0);
            if (hold_phase) begin
                sink_hold_req = 1'b1;
            end
            repeat ($urandom_range(8, 20)) begin
                if (hold_phase) begin
                    n = $urandom_range(0, 3);
                end else if ($urandom_range(0, 19) == 0) begin
                    n = $urandom_range(25, 90);
                end else begin
                    n = $urandom_range(0, 24);
                end
                send_line(n, $urandom_range(0, 2) != 0);
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
